// File: rtl/iafd_pkg.sv
// Shared types, constants and operation codes for the integer ALU with float divide.
`timescale 1ns / 1ps
`default_nettype none

package iafd_pkg;

    // Operand width and the derived widths of the divider chain.
    localparam int DATA_WIDTH  = 32;
    localparam int LZ_W        = $clog2(DATA_WIDTH);
    localparam int NORM_STAGES = LZ_W;
    localparam int QBITS       = 56;
    localparam int SHF_W       = 64;

    // Double-precision constants.
    localparam logic [10:0] EXP_BIAS = 11'd1023;
    localparam logic [63:0] POS_INF  = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] NEG_INF  = 64'hFFF0_0000_0000_0000;
    localparam logic [63:0] QNAN     = 64'h7FF8_0000_0000_0000;

    // Operation codes.
    typedef enum logic [2:0] {
        FN_ADD = 3'd0,
        FN_SUB = 3'd1,
        FN_MUL = 3'd2,
        FN_REM = 3'd3,
        FN_XOR = 3'd4,
        FN_OR  = 3'd5,
        FN_AND = 3'd6,
        FN_DIV = 3'd7
    } func_t;

    // Side information that travels with each beat.
    typedef struct packed {
        func_t                 func;
        logic                  a_neg;
        logic                  b_neg;
        logic                  a_zero;
        logic                  b_zero;
        logic                  fault;
        logic [DATA_WIDTH-1:0] int_res;
        logic [LZ_W-1:0]       la;
        logic [LZ_W-1:0]       lb;
    } meta_t;

    // Normaliser stage contents: raw magnitudes and normalised mantissas.
    typedef struct packed {
        logic [DATA_WIDTH-1:0] ua;
        logic [DATA_WIDTH-1:0] ub;
        logic [DATA_WIDTH-1:0] ma;
        logic [DATA_WIDTH-1:0] mb;
        meta_t                 meta;
    } norm_t;

    // Divider cell contents: partial remainder, divisor and shift word.
    typedef struct packed {
        logic [DATA_WIDTH-1:0] rem;
        logic [DATA_WIDTH-1:0] dvs;
        logic [SHF_W-1:0]      shf;
        meta_t                 meta;
    } cell_t;

    // One result beat.
    typedef struct packed {
        logic [DATA_WIDTH-1:0] int_result;
        logic [63:0]           float_bits;
        logic                  is_float;
        logic                  fault;
    } res_t;

endpackage

`default_nettype wire

// File: rtl/integer_alu_with_float_divide.sv
// Top level of the integer ALU with a correctly rounded double-precision divide.
//
// Both channels use valid/ready; a beat moves when valid and ready are high
// at the same rising edge. One result beat leaves for every operand beat,
// in order.
// Add, subtract, multiply and the bitwise operations are worked out as the
// beat enters. Remainder and divide run through a row of 56 restoring
// division cells, one quotient bit per cell, behind a five-stage
// leading-zero normaliser.
// Every beat takes the same path: the entry stage, 5 normaliser stages,
// 56 cells and the result register. A new beat is taken every cycle while
// the skid register is empty.
// When the receiver holds ready low, one result is caught in a skid
// register and the whole pipeline then holds; ready on the input side
// falls until the skid register drains.
// Reset empties every stage and the skid register; no result is pending
// afterwards.
`timescale 1ns / 1ps
`default_nettype none

module integer_alu_with_float_divide
    import iafd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] operand_a,
    input  wire logic [31:0] operand_b,
    input  wire logic [2:0]  func,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      int_result,
    output logic [63:0]      float_bits,
    output logic             is_float,
    output logic             fault
);

    logic en;

    // Entry stage: magnitudes, the simple operations and the remainder fault.
    logic                  a_neg;
    logic                  b_neg;
    logic [DATA_WIDTH-1:0] ua;
    logic [DATA_WIDTH-1:0] ub;
    logic [DATA_WIDTH-1:0] prod;
    func_t                 fn;
    norm_t                 s0_next;
    norm_t                 s0_data_reg;
    logic                  s0_valid_reg;

    assign fn    = func_t'(func);
    assign a_neg = operand_a[DATA_WIDTH-1];
    assign b_neg = operand_b[DATA_WIDTH-1];
    assign ua    = a_neg ? (~operand_a + 1'b1) : operand_a;
    assign ub    = b_neg ? (~operand_b + 1'b1) : operand_b;
    assign prod  = operand_a * operand_b;

    always_comb
    begin
        s0_next             = '0;
        s0_next.ua          = ua;
        s0_next.ub          = ub;
        s0_next.ma          = ua;
        s0_next.mb          = ub;
        s0_next.meta.func   = fn;
        s0_next.meta.a_neg  = a_neg;
        s0_next.meta.b_neg  = b_neg;
        s0_next.meta.a_zero = (operand_a == '0);
        s0_next.meta.b_zero = (operand_b == '0);
        s0_next.meta.fault  = (fn == FN_REM) &&
                              ((operand_b == '0) ||
                               ((operand_a == {1'b1, {(DATA_WIDTH-1){1'b0}}}) &&
                                (operand_b == '1)));
        unique case (fn)
            FN_ADD:  s0_next.meta.int_res = operand_a + operand_b;
            FN_SUB:  s0_next.meta.int_res = operand_a - operand_b;
            FN_MUL:  s0_next.meta.int_res = prod;
            FN_XOR:  s0_next.meta.int_res = operand_a ^ operand_b;
            FN_OR:   s0_next.meta.int_res = operand_a | operand_b;
            FN_AND:  s0_next.meta.int_res = operand_a & operand_b;
            default: s0_next.meta.int_res = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (en)
            s0_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s0_data_reg <= s0_next;
    end

    // Normaliser.
    logic  nm_valid;
    norm_t nm_data;

    iafd_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s0_valid_reg),
        .in_data   (s0_data_reg),
        .out_valid (nm_valid),
        .out_data  (nm_data)
    );

    // Chain entry: divide starts from the normalised mantissas, remainder
    // feeds the raw dividend in bit by bit.
    cell_t chain_data  [QBITS+1];
    logic  chain_valid [QBITS+1];

    always_comb
    begin
        chain_data[0].meta = nm_data.meta;
        if (nm_data.meta.func == FN_DIV)
        begin
            chain_data[0].rem = {1'b0, nm_data.ma[DATA_WIDTH-1:1]};
            chain_data[0].dvs = nm_data.mb;
            chain_data[0].shf = {nm_data.ma[0], {(SHF_W-1){1'b0}}};
        end
        else
        begin
            chain_data[0].rem = '0;
            chain_data[0].dvs = nm_data.ub;
            chain_data[0].shf = {{(QBITS-DATA_WIDTH){1'b0}}, nm_data.ua,
                                 {(SHF_W-QBITS){1'b0}}};
        end
    end
    assign chain_valid[0] = nm_valid;

    for (genvar i = 0; i < QBITS; i++) begin : g_cell
        iafd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    // Result stage: rounding of the quotient and the sign of the remainder.
    cell_t                 lc;
    logic [QBITS-1:0]      q;
    logic                  hi;
    logic [51:0]           mant;
    logic                  guard;
    logic                  sticky;
    logic                  rup;
    logic [10:0]           expo;
    logic [62:0]           mag;
    logic                  sgn;
    logic [63:0]           fbits;
    logic [DATA_WIDTH-1:0] srem;
    res_t                  res_next;
    res_t                  res_reg;
    logic                  res_valid_reg;

    always_comb
    begin
        lc     = chain_data[QBITS];
        q      = lc.shf[QBITS-1:0];
        hi     = q[QBITS-1];
        mant   = hi ? q[QBITS-2:3] : q[QBITS-3:2];
        guard  = hi ? q[2] : q[1];
        sticky = (hi ? (q[1] | q[0]) : q[0]) | (lc.rem != '0);
        rup    = guard & (sticky | mant[0]);
        expo   = EXP_BIAS + 11'(lc.meta.lb) - 11'(lc.meta.la) - 11'(!hi);
        mag    = {expo, mant} + 63'(rup);
        sgn    = lc.meta.a_neg ^ lc.meta.b_neg;

        // Zero divisor gives infinity or NaN; zero dividend gives a signed zero.
        if (lc.meta.b_zero)
        begin
            if (lc.meta.a_zero)
                fbits = QNAN;
            else if (lc.meta.a_neg)
                fbits = NEG_INF;
            else
                fbits = POS_INF;
        end
        else if (lc.meta.a_zero)
            fbits = {sgn, 63'b0};
        else
            fbits = {sgn, mag};

        srem = lc.meta.a_neg ? (~lc.rem + 1'b1) : lc.rem;

        res_next          = '0;
        res_next.fault    = lc.meta.fault;
        case (lc.meta.func)
            FN_DIV:
            begin
                res_next.is_float   = 1'b1;
                res_next.float_bits = fbits;
            end
            FN_REM:
            begin
                res_next.int_result = lc.meta.fault ? '0 : srem;
            end
            default:
            begin
                res_next.int_result = lc.meta.int_res;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (en)
            res_valid_reg <= chain_valid[QBITS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    // Skid register: catches the result beat when the receiver stalls.
    logic skid_full_reg;
    logic skid_full_next;
    res_t skid_reg;
    res_t out_sel;

    assign en = !skid_full_reg;

    always_comb
    begin
        skid_full_next = skid_full_reg;
        if (skid_full_reg && out_ready)
            skid_full_next = 1'b0;
        else if (en && res_valid_reg && !out_ready)
            skid_full_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_full_reg <= 1'b0;
        else
            skid_full_reg <= skid_full_next;
    end

    always_ff @(posedge clk)
    begin
        if (en && res_valid_reg && !out_ready)
            skid_reg <= res_reg;
    end

    assign out_sel    = skid_full_reg ? skid_reg : res_reg;
    assign in_ready   = en;
    assign out_valid  = skid_full_reg | res_valid_reg;
    assign int_result = out_sel.int_result;
    assign float_bits = out_sel.float_bits;
    assign is_float   = out_sel.is_float;
    assign fault      = out_sel.fault;

    // A divide never faults and carries no integer result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_float |-> !fault && (int_result == '0))
    else $error("divide result with fault or integer bits");

    // Integer results leave the float field clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_float |-> (float_bits == '0))
    else $error("integer result with float bits set");

    // A faulting remainder returns zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fault |-> (int_result == '0))
    else $error("fault with non-zero result");

    // A full skid register drains as soon as the receiver takes the beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg && out_ready |=> !skid_full_reg)
    else $error("skid register failed to drain");

endmodule

`default_nettype wire

// File: rtl/iafd_norm.sv
// Pipelined leading-zero normaliser for both operand magnitudes.
`timescale 1ns / 1ps
`default_nettype none

module iafd_norm
    import iafd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire logic  in_valid,
    input  wire norm_t in_data,
    output logic       out_valid,
    output norm_t      out_data
);

    norm_t stage_data  [NORM_STAGES];
    logic  stage_valid [NORM_STAGES];

    for (genvar k = 0; k < NORM_STAGES; k++) begin : g_stage
        localparam int SH = (DATA_WIDTH / 2) >> k;

        norm_t src;
        logic  src_valid;
        norm_t data_next;
        norm_t data_reg;
        logic  valid_reg;

        if (k == 0) begin : g_first
            assign src       = in_data;
            assign src_valid = in_valid;
        end
        else begin : g_rest
            assign src       = stage_data[k-1];
            assign src_valid = stage_valid[k-1];
        end

        // Shift each mantissa by this stage's amount when its top bits are all zero.
        always_comb
        begin
            data_next = src;
            if (src.ma[DATA_WIDTH-1 -: SH] == '0)
            begin
                data_next.ma      = src.ma << SH;
                data_next.meta.la = src.meta.la | LZ_W'(SH);
            end
            if (src.mb[DATA_WIDTH-1 -: SH] == '0)
            begin
                data_next.mb      = src.mb << SH;
                data_next.meta.lb = src.meta.lb | LZ_W'(SH);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg <= 1'b0;
            else if (en)
                valid_reg <= src_valid;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                data_reg <= data_next;
        end

        assign stage_data[k]  = data_reg;
        assign stage_valid[k] = valid_reg;
    end

    assign out_valid = stage_valid[NORM_STAGES-1];
    assign out_data  = stage_data[NORM_STAGES-1];

endmodule

`default_nettype wire

// File: rtl/iafd_cell.sv
// One restoring-division cell: a compare, a conditional subtract and a one-bit shift.
`timescale 1ns / 1ps
`default_nettype none

module iafd_cell
    import iafd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire logic  in_valid,
    input  wire cell_t in_data,
    output logic       out_valid,
    output cell_t      out_data
);

    logic [DATA_WIDTH:0]   part;
    logic [DATA_WIDTH+1:0] diff;
    logic                  ge;
    cell_t                 data_next;
    logic                  valid_reg;
    cell_t                 data_reg;

    // Bring in the next dividend bit and try the subtraction.
    always_comb
    begin
        part      = {in_data.rem, in_data.shf[SHF_W-1]};
        diff      = {1'b0, part} - {2'b00, in_data.dvs};
        ge        = !diff[DATA_WIDTH+1];
        data_next = in_data;
        data_next.rem = ge ? diff[DATA_WIDTH-1:0] : part[DATA_WIDTH-1:0];
        data_next.shf = {in_data.shf[SHF_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// File: sim/tb_integer_alu_with_float_divide.sv
// Self-checking testbench for the integer ALU with float divide.
`timescale 1ns / 1ps

module tb_integer_alu_with_float_divide;
    import iafd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int RANDOM_BEATS   = 1000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [2:0]  func;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] int_result;
    logic [63:0] float_bits;
    logic        is_float;
    logic        fault;

    res_t pending_results[$];
    int   mismatch_count;
    int   idle_cycles;

    integer_alu_with_float_divide u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operand_a  (operand_a),
        .operand_b  (operand_b),
        .func       (func),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .int_result (int_result),
        .float_bits (float_bits),
        .is_float   (is_float),
        .fault      (fault)
    );

    // Clock with a 12 ns period.
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Works out the result beat that one operand beat should produce.
    function automatic res_t alu_result(logic [31:0] a, logic [31:0] b, func_t op);
        res_t       r;
        logic signed [31:0] sa;
        logic signed [31:0] sb;
        real        quotient;
        sa = a;
        sb = b;
        r  = '0;
        case (op)
            FN_ADD: r.int_result = a + b;
            FN_SUB: r.int_result = a - b;
            FN_MUL: r.int_result = a * b;
            FN_REM:
            begin
                if (sb == 0 || (a == 32'h8000_0000 && b == 32'hFFFF_FFFF))
                    r.fault = 1'b1;
                else
                    r.int_result = sa % sb;
            end
            FN_XOR: r.int_result = a ^ b;
            FN_OR:  r.int_result = a | b;
            FN_AND: r.int_result = a & b;
            default:
            begin
                r.is_float = 1'b1;
                if (sb == 0)
                begin
                    if (sa > 0)
                        r.float_bits = POS_INF;
                    else if (sa < 0)
                        r.float_bits = NEG_INF;
                    else
                        r.float_bits = QNAN;
                end
                else
                begin
                    quotient     = real'(longint'(sa)) / real'(longint'(sb));
                    r.float_bits = $realtobits(quotient);
                end
            end
        endcase
        return r;
    endfunction

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
    endtask

    // Sends one operand beat; valid stays high after return until the caller pauses.
    task automatic send_beat(logic [31:0] a, logic [31:0] b, func_t op);
        @(negedge clk);
        in_valid  <= 1'b1;
        operand_a <= a;
        operand_b <= b;
        func      <= op;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(alu_result(a, b, op));
    endtask

    // Drops valid for a number of cycles.
    task automatic pause_sender(int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0;
            4:       return 32'($urandom_range(0, 16)) - 32'd8;
            default: return $urandom;
        endcase
    endfunction

    // Receiver stall pattern: phases of always ready, random stalls and long holds.
    int   stall_phase;
    int   phase_left;
    int   hold_left;
    always @(negedge clk)
    begin
        if (phase_left == 0)
        begin
            stall_phase = $urandom_range(0, 2);
            phase_left  = $urandom_range(20, 200);
        end
        phase_left--;
        case (stall_phase)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            default:
            begin
                if (hold_left > 0)
                begin
                    hold_left--;
                    out_ready <= 1'b0;
                end
                else
                begin
                    hold_left = $urandom_range(0, 15);
                    out_ready <= 1'b1;
                end
            end
        endcase
    end

    // Checks each result beat against the oldest expectation.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", 64'(int_result), 64'd0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (int_result !== want.int_result)
                    report_mismatch("int_result", 64'(int_result), 64'(want.int_result));
                if (float_bits !== want.float_bits)
                    report_mismatch("float_bits", float_bits, want.float_bits);
                if (is_float !== want.is_float)
                    report_mismatch("is_float", 64'(is_float), 64'(want.is_float));
                if (fault !== want.fault)
                    report_mismatch("fault", 64'(fault), 64'(want.fault));
            end
        end
    end

    // Watchdog on cycles in which no beat moves on either side.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Extremes of the operands through every operation.
    task automatic test_operation_extremes();
        func_t op;
        for (int i = 0; i < 8; i++)
        begin
            op = func_t'(i);
            send_beat(32'h7FFF_FFFF, 32'h8000_0000, op);
        end
        send_beat(32'h8000_0000, 32'h8000_0000, FN_MUL);
        send_beat(32'hFFFF_FFFF, 32'h7FFF_FFFF, FN_ADD);
        send_beat(32'h8000_0000, 32'h0000_0001, FN_SUB);
        send_beat(32'hFFFF_FFF9, 32'h0000_0002, FN_REM);
        pause_sender(3);
    endtask

    // Remainder faults: zero divisor and minimum by minus one; minimum by one does not fault.
    task automatic test_remainder_faults();
        send_beat(32'h0000_0007, 32'h0, FN_REM);
        send_beat(32'h8000_0000, 32'hFFFF_FFFF, FN_REM);
        send_beat(32'h8000_0000, 32'h0000_0001, FN_REM);
        pause_sender(2);
    endtask

    // Divide by zero with each dividend sign, zero by zero, then min by -1, 1 by 3, max by min and 0 by -1.
    task automatic test_divide_special_cases();
        send_beat(32'h0000_0005, 32'h0, FN_DIV);
        send_beat(32'hFFFF_FFFB, 32'h0, FN_DIV);
        send_beat(32'h0, 32'h0, FN_DIV);
        send_beat(32'h8000_0000, 32'hFFFF_FFFF, FN_DIV);
        send_beat(32'h0000_0001, 32'h0000_0003, FN_DIV);
        send_beat(32'h7FFF_FFFF, 32'h8000_0000, FN_DIV);
        send_beat(32'h0, 32'hFFFF_FFFF, FN_DIV);
        pause_sender(1);
    endtask

    // Random beats in bursts of random length with random gaps.
    task automatic test_random_traffic();
        int sent;
        int burst;
        sent = 0;
        while (sent < RANDOM_BEATS)
        begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst; i++)
            begin
                send_beat(pick_operand(), pick_operand(), func_t'($urandom_range(0, 7)));
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 10));
        end
        pause_sender(1);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        operand_a      = '0;
        operand_b      = '0;
        func           = FN_ADD;
        out_ready      = 1'b0;
        mismatch_count = 0;
        idle_cycles    = 0;
        phase_left     = 0;
        hold_left      = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_operation_extremes();
        test_remainder_faults();
        test_divide_special_cases();
        test_random_traffic();

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/iafd_pkg.sv
rtl/iafd_norm.sv
rtl/iafd_cell.sv
rtl/integer_alu_with_float_divide.sv
sim/tb_integer_alu_with_float_divide.sv
